### sv/psgs_pkg.sv
// ---------------------------------------------------------------------------
// psgs_pkg
// shared constants, types and helper functions of the gauss-seidel solver
// ---------------------------------------------------------------------------
package psgs_pkg;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int ADDR_W    = $clog2(CELLS);

  // circle centers, integer division as in the spec
  localparam int CEN_QR = GRID_ROWS / 4;
  localparam int CEN_TR = (3 * GRID_ROWS) / 4;
  localparam int CEN_HR = GRID_ROWS / 2;
  localparam int CEN_QC = GRID_COLS / 4;
  localparam int CEN_TC = (3 * GRID_COLS) / 4;
  localparam int CEN_HC = GRID_COLS / 2;

  localparam int IDX_W = ((ROW_W > COL_W) ? ROW_W : COL_W) + 2;
  localparam int SQ_W  = 2 * IDX_W + 1;
  localparam int R2_W  = 26;
  localparam int CMP_W = (SQ_W > R2_W) ? SQ_W : R2_W;

  localparam int VAL_W = 48;
  localparam int CHG_W = 47;
  localparam int WGT_W = 16;
  localparam int RAD_W = 13;
  localparam int SWP_W = 16;
  localparam int CFG_W = 47;
  localparam int CFG_IDX_W = 3;

  localparam logic [WGT_W-1:0] WGT_ONE = 16'd32768;
  localparam logic [CHG_W-1:0] CHG_MAX = {CHG_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHT_V   = 3'd0,
    REG_WEIGHT_H   = 3'd1,
    REG_SRC_OFFSET = 3'd2,
    REG_RADIUS     = 3'd3,
    REG_TOLERANCE  = 3'd4,
    REG_MAX_SWEEPS = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    MODE_SOLVE = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(GRID_COLS) + ADDR_W'(c);
  endfunction

  function automatic logic near(logic [ROW_W-1:0] i, logic [COL_W-1:0] j,
                                int ci, int cj, logic [R2_W-1:0] r2);
    logic signed [IDX_W-1:0] di;
    logic signed [IDX_W-1:0] dj;
    logic signed [SQ_W-1:0]  dis;
    logic signed [SQ_W-1:0]  djs;
    logic [SQ_W-1:0]         d2;
    di = $signed(IDX_W'(i)) - $signed(IDX_W'(ci));
    dj = $signed(IDX_W'(j)) - $signed(IDX_W'(cj));
    // widen before squaring so the product keeps all its bits
    dis = SQ_W'(di);
    djs = SQ_W'(dj);
    d2 = $unsigned(dis * dis) + $unsigned(djs * djs);
    return CMP_W'(d2) <= CMP_W'(r2);
  endfunction

  function automatic logic in_zone(logic [ROW_W-1:0] i, logic [COL_W-1:0] j,
                                   logic [R2_W-1:0] r2);
    return near(i, j, CEN_QR, CEN_QC, r2) || near(i, j, CEN_TR, CEN_TC, r2) ||
           near(i, j, CEN_QR, CEN_TC, r2) || near(i, j, CEN_TR, CEN_QC, r2) ||
           near(i, j, CEN_HR, CEN_HC, r2);
  endfunction

endpackage

### sv/psgs_if.sv
// ---------------------------------------------------------------------------
// psgs channels
// command and result channels with valid/ready handshake
// ---------------------------------------------------------------------------
interface psgs_cmd_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [5:0] row;
  logic [5:0] col;
  modport source (output valid, output mode, output row, output col, input ready);
  modport sink (input valid, input mode, input row, input col, output ready);
endinterface

interface psgs_res_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] cell_value;
  logic [15:0]        sweeps_done;
  logic [46:0]        last_change;
  logic               converged;
  modport source (output valid, output cell_value, output sweeps_done,
                  output last_change, output converged, input ready);
  modport sink (input valid, input cell_value, input sweeps_done,
                input last_change, input converged, output ready);
endinterface

### sv/poisson_gauss_seidel_solver_core.sv
// ---------------------------------------------------------------------------
// poisson_gauss_seidel_solver_core
// gauss-seidel five-point poisson solver over a grid held in block memory
// ---------------------------------------------------------------------------
//  channel | dir | beat contents
//  cmd     | in  | mode, row, col
//  res     | out | cell_value, sweeps_done, last_change, converged
//  cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// after reset a clearing pass writes zero to all 4096 cells, and cmd.ready
// stays low meanwhile. a read beat is registered through the read and finish
// states before it is valid. a solve runs per sweep a zeroing pass over the
// 63*63 cells from row and column 1, a read-compute-write loop over the
// 62*62 interior cells and a closing step, on the single grid memory.
// a finished beat waits in the result register; a new command is taken then.
// ---------------------------------------------------------------------------
module poisson_gauss_seidel_solver_core (
  input  logic                            clk,
  input  logic                            rst,
  psgs_cmd_if.sink                        cmd,
  psgs_res_if.source                      res,
  input  logic                            cfg_we,
  input  logic [psgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psgs_pkg::CFG_W-1:0]      cfg_data
);
  import psgs_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_ZERO, S_UA, S_UB, S_UC, S_UW, S_SWEEP_END, S_FIN
  } state_t;

  state_t state;

  logic [WGT_W-1:0] weight_v, weight_h;
  logic [CHG_W-1:0] src_offset, tolerance;
  logic [RAD_W-1:0] radius;
  logic [SWP_W-1:0] max_sweeps;

  logic [ADDR_W-1:0]       clr_addr;
  logic [ROW_W-1:0]        i;
  logic [COL_W-1:0]        j;
  logic [R2_W-1:0]         r2;
  logic [SWP_W-1:0]        sweeps;
  logic [CHG_W-1:0]        biggest, recent;
  logic signed [VAL_W:0]   sv_sum;
  logic signed [VAL_W-1:0] left;
  logic                    rd_zero;

  logic signed [VAL_W-1:0] out_value;
  logic [SWP_W-1:0]        out_sweeps;
  logic [CHG_W-1:0]        out_change;
  logic                    out_conv;
  logic                    res_valid;

  logic [ADDR_W-1:0] center, addr_a, addr_b, waddr;
  logic [VAL_W-1:0]  q_a, q_b, wdata;
  logic              we;
  logic              upd_go, upd_done;
  logic signed [VAL_W-1:0] upd_nv;
  logic [CHG_W-1:0]  upd_change;
  logic              load_res;

  assign center = cell_addr(i, j);

  always_comb begin
    addr_a = center;
    addr_b = center;
    we     = 1'b0;
    waddr  = center;
    wdata  = '0;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
      end
      S_ZERO: we = in_zone(i, j, r2);
      S_UA: begin
        addr_a = center - ADDR_W'(GRID_COLS);
        addr_b = center + ADDR_W'(GRID_COLS);
      end
      S_UB: addr_b = center + ADDR_W'(1);
      S_UW: begin
        we    = upd_done;
        wdata = upd_nv;
      end
      default: ;
    endcase
    if (state == S_IDLE) begin
      addr_a = cell_addr(ROW_W'(cmd.row), COL_W'(cmd.col));
    end
  end

  assign upd_go   = (state == S_UC);
  assign load_res = (state == S_FIN) && (!res_valid || res.ready);

  psgs_grid_ram u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .q_a    (q_a),
    .q_b    (q_b)
  );

  psgs_update u_update (
    .clk    (clk),
    .rst    (rst),
    .go     (upd_go),
    .sv     (sv_sum),
    .left   (left),
    .right  ($signed(q_b)),
    .old    ($signed(q_a)),
    .wv_raw (weight_v),
    .wh_raw (weight_h),
    .offset (src_offset),
    .done   (upd_done),
    .nv     (upd_nv),
    .change (upd_change)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_v   <= 16'd8192;
      weight_h   <= 16'd8192;
      src_offset <= 47'd175922;
      radius     <= 13'd8;
      tolerance  <= '0;
      max_sweeps <= 16'd10000;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WEIGHT_V:   weight_v   <= cfg_data[WGT_W-1:0];
        REG_WEIGHT_H:   weight_h   <= cfg_data[WGT_W-1:0];
        REG_SRC_OFFSET: src_offset <= cfg_data;
        REG_RADIUS:     radius     <= cfg_data[RAD_W-1:0];
        REG_TOLERANCE:  tolerance  <= cfg_data;
        REG_MAX_SWEEPS: max_sweeps <= cfg_data[SWP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      recent    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd.valid) begin
            if (cmd.mode == MODE_READ) begin
              rd_zero <= !(({7'd0, cmd.row} < 13'(GRID_ROWS)) &&
                           ({7'd0, cmd.col} < 13'(GRID_COLS)));
              state   <= S_READ;
            end else begin
              sweeps     <= '0;
              out_conv   <= 1'b0;
              out_value  <= '0;
              r2         <= R2_W'(radius) * R2_W'(radius);
              biggest    <= '0;
              i          <= ROW_W'(1);
              j          <= COL_W'(1);
              state      <= (max_sweeps == '0) ? S_SWEEP_END : S_ZERO;
            end
          end
        end
        S_READ: begin
          out_value  <= rd_zero ? '0 : $signed(q_a);
          out_sweeps <= '0;
          out_conv   <= 1'b0;
          out_change <= recent;
          state      <= S_FIN;
        end
        S_ZERO: begin
          if (j == COL_W'(GRID_COLS - 1)) begin
            j <= COL_W'(1);
            if (i == ROW_W'(GRID_ROWS - 1)) begin
              i     <= ROW_W'(1);
              left  <= '0;
              state <= S_UA;
            end else begin
              i <= i + ROW_W'(1);
            end
          end else begin
            j <= j + COL_W'(1);
          end
        end
        S_UA: state <= S_UB;
        S_UB: begin
          sv_sum <= {q_a[VAL_W-1], q_a} + {q_b[VAL_W-1], q_b};
          state  <= S_UC;
        end
        S_UC: state <= S_UW;
        S_UW: begin
          if (upd_done) begin
            if (upd_change > biggest) begin
              biggest <= upd_change;
            end
            if (j == COL_W'(GRID_COLS - 2)) begin
              j    <= COL_W'(1);
              left <= '0;
              if (i == ROW_W'(GRID_ROWS - 2)) begin
                state <= S_SWEEP_END;
              end else begin
                i     <= i + ROW_W'(1);
                state <= S_UA;
              end
            end else begin
              j     <= j + COL_W'(1);
              left  <= upd_nv;
              state <= S_UA;
            end
          end
        end
        S_SWEEP_END: begin
          // a zero sweep limit lands here straight from idle
          if (max_sweeps == '0) begin
            out_sweeps <= '0;
            out_change <= recent;
            state      <= S_FIN;
          end else begin
            recent     <= biggest;
            sweeps     <= sweeps + SWP_W'(1);
            out_sweeps <= sweeps + SWP_W'(1);
            out_change <= biggest;
            if (biggest <= tolerance) begin
              out_conv <= 1'b1;
              state    <= S_FIN;
            end else if (sweeps + SWP_W'(1) == max_sweeps) begin
              state <= S_FIN;
            end else begin
              biggest <= '0;
              i       <= ROW_W'(1);
              j       <= COL_W'(1);
              state   <= S_ZERO;
            end
          end
        end
        S_FIN: begin
          if (load_res) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res.cell_value  <= out_value;
      res.sweeps_done <= out_sweeps;
      res.last_change <= out_change;
      res.converged   <= out_conv;
    end
  end

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = res_valid;

  a_conv_within_tol: assert property (@(posedge clk) disable iff (rst)
    load_res && out_conv |-> out_change <= tolerance)
    else $error("converged result above tolerance");

  a_sweeps_bounded: assert property (@(posedge clk) disable iff (rst)
    load_res |-> out_sweeps <= max_sweeps)
    else $error("sweep count beyond limit");

  a_update_in_wait: assert property (@(posedge clk) disable iff (rst)
    upd_done |-> state == S_UW)
    else $error("datapath result outside write state");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !cmd.ready)
    else $error("command taken before clearing pass");

endmodule

### sv/psgs_grid_ram.sv
// ---------------------------------------------------------------------------
// psgs_grid_ram
// grid storage: one write port, two read ports with registered data
// ---------------------------------------------------------------------------
module psgs_grid_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [psgs_pkg::ADDR_W-1:0]  waddr,
  input  logic [psgs_pkg::VAL_W-1:0]   wdata,
  input  logic [psgs_pkg::ADDR_W-1:0]  addr_a,
  input  logic [psgs_pkg::ADDR_W-1:0]  addr_b,
  output logic [psgs_pkg::VAL_W-1:0]   q_a,
  output logic [psgs_pkg::VAL_W-1:0]   q_b
);
  import psgs_pkg::*;

  logic [VAL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q_a <= mem[addr_a];
    q_b <= mem[addr_b];
  end

endmodule

### sv/psgs_update.sv
// ---------------------------------------------------------------------------
// psgs_update
// four-stage relaxation datapath: weighted neighbor sum, offset, change
// ---------------------------------------------------------------------------
module psgs_update (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic signed [psgs_pkg::VAL_W:0]   sv,
  input  logic signed [psgs_pkg::VAL_W-1:0] left,
  input  logic signed [psgs_pkg::VAL_W-1:0] right,
  input  logic signed [psgs_pkg::VAL_W-1:0] old,
  input  logic [psgs_pkg::WGT_W-1:0]        wv_raw,
  input  logic [psgs_pkg::WGT_W-1:0]        wh_raw,
  input  logic [psgs_pkg::CHG_W-1:0]        offset,
  output logic                              done,
  output logic signed [psgs_pkg::VAL_W-1:0] nv,
  output logic [psgs_pkg::CHG_W-1:0]        change
);
  import psgs_pkg::*;

  logic [3:0] vld;
  logic signed [VAL_W:0]     sv0, sh0;
  logic signed [VAL_W-1:0]   old0, old1, old2, nv2;
  logic signed [WGT_W+1:0]   wv_s, wh_s;
  logic signed [VAL_W+18:0]  pv, ph;
  logic signed [VAL_W+4:0]   sum;
  logic signed [VAL_W-1:0]   sat;
  logic signed [VAL_W:0]     diff;
  logic [VAL_W:0]            mag;

  // weights above one are used as one
  assign wv_s = (wv_raw > WGT_ONE) ? $signed({2'b00, WGT_ONE}) : $signed({2'b00, wv_raw});
  assign wh_s = (wh_raw > WGT_ONE) ? $signed({2'b00, WGT_ONE}) : $signed({2'b00, wh_raw});

  // arithmetic shift gives the floor of the scaled product
  assign sum = (VAL_W+5)'(pv >>> 15) + (VAL_W+5)'(ph >>> 15)
             - $signed({6'b000000, offset});

  always_comb begin
    if (sum[VAL_W+4:VAL_W-1] == {6{1'b0}} || sum[VAL_W+4:VAL_W-1] == {6{1'b1}}) begin
      sat = sum[VAL_W-1:0];
    end else if (sum[VAL_W+4]) begin
      sat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  assign diff = {old2[VAL_W-1], old2} - {nv2[VAL_W-1], nv2};
  assign mag  = diff[VAL_W] ? $unsigned(-diff) : $unsigned(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], go};
    end
    if (go) begin
      sv0  <= sv;
      sh0  <= {left[VAL_W-1], left} + {right[VAL_W-1], right};
      old0 <= old;
    end
    pv   <= sv0 * wv_s;
    ph   <= sh0 * wh_s;
    old1 <= old0;
    nv2  <= sat;
    old2 <= old1;
    nv   <= nv2;
    change <= (mag[VAL_W:CHG_W] != 2'b00) ? CHG_MAX : mag[CHG_W-1:0];
  end

  assign done = vld[3];

endmodule
